// ===== design/sdsce_pkg.sv =====
// Package for the SD card SPI-mode command engine: item types, result kinds,
// phase encoding and frame constants. No dependencies.
`timescale 1ns / 1ps
package sdsce_pkg;

	localparam int FRAME_BYTES = 6;

	localparam logic [7:0] START_BITS    = 8'h40;
	localparam logic [7:0] CRC_POLY      = 8'h89;
	localparam logic [7:0] TIMEOUT_RESET = 8'd200;
	localparam int         BUSY_BIT      = 7;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_RECEIVE = 1'b1;

	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_RESP    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_RESP = 2'd2
	} phase_t;

	typedef struct packed {
		logic        opcode;
		logic [5:0]  command_index;
		logic [31:0] command_argument;
		logic [4:0]  response_length;
		logic [7:0]  received_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] data_byte;
		logic       last;
	} out_item_t;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

endpackage

// ===== design/sdsce_frame_build.sv =====
// Command frame builder: start byte, big-endian argument, CRC7 end byte.
// Depends on sdsce_pkg.
`timescale 1ns / 1ps
module sdsce_frame_build import sdsce_pkg::*; (
	input  logic [5:0]  command_index,
	input  logic [31:0] command_argument,
	output frame_t      frame
);

	logic [4:0][7:0] head;
	logic [7:0]      crc;

	assign head[0] = START_BITS | {2'b00, command_index};
	assign head[1] = command_argument[31:24];
	assign head[2] = command_argument[23:16];
	assign head[3] = command_argument[15:8];
	assign head[4] = command_argument[7:0];

	// CRC7 kept in the upper seven bits of an 8-bit register, msb first
	always_comb begin
		crc = '0;
		for (int i = 0; i < 5; i++) begin
			crc = crc ^ head[i];
			for (int j = 0; j < 8; j++) begin
				if (crc[7]) begin
					crc = crc ^ CRC_POLY;
				end
				crc = {crc[6:0], 1'b0};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 5; i++) begin
			frame[i] = head[i];
		end
		frame[FRAME_BYTES-1] = crc | 8'h01;
	end

endmodule

// ===== design/sd_spi_command_engine.sv =====
// Top level of the SD card SPI-mode command engine: input stage, phase
// logic and result queue. Depends on sdsce_pkg and sdsce_frame_build.
`timescale 1ns / 1ps
//
//  channel  | signals                            | payload
//  ---------+------------------------------------+---------------------------
//  item     | item_valid / item_ready            | item   (in_item_t)
//  result   | result_valid / result_ready        | result (out_item_t)
//  cfg      | cfg_valid / cfg_ready (always 1)   | cfg_data, response_timeout
//
// An accepted item is held in the input stage, then updates the phase
// state and loads its results into a six-entry result queue, from whose
// head the first result is shown. Receive items sustain one item per cycle
// while results are taken, since each gives at most one result and the
// queue reloads in the cycle its last entry leaves. A start item fills the
// queue with the six-byte frame, so the next item waits in the input stage
// until the last frame byte leaves. Reset clears the phase, counters, queue
// count and input stage and loads the timeout register with 200. A stall on
// the result side holds the queue, then the input stage, then drops item_ready.
module sd_spi_command_engine import sdsce_pkg::*; #(
	parameter int MAX_RESPONSE_BYTES = 17
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam logic [4:0] MaxLen = 5'(MAX_RESPONSE_BYTES);

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// phase state
	phase_t     phase_q, phase_d;
	logic [7:0] poll_q, poll_d;
	logic [4:0] rem_q, rem_d;
	logic [7:0] tmo_q;

	// result queue
	out_item_t [FRAME_BYTES-1:0] res_s2;
	out_item_t [FRAME_BYTES-1:0] res_d;
	logic [2:0]                  cnt_q;
	logic [2:0]                  nres_d;

	logic       adv;
	frame_t     frame;
	logic [7:0] poll_inc;
	logic [7:0] limit;
	logic [4:0] rem_dec;
	logic [4:0] len_sat;
	logic       take_resp;

	assign cfg_ready = 1'b1;

	// Move the staged item on when its results fit: queue empty, or its
	// final entry leaves this cycle.
	assign adv        = valid_s1 && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && result_ready));
	assign item_ready = !valid_s1 || adv;

	assign result_valid = (cnt_q != 3'd0);
	assign result       = res_s2[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tmo_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	sdsce_frame_build u_frame (
		.command_index    (item_s1.command_index),
		.command_argument (item_s1.command_argument),
		.frame            (frame)
	);

	assign poll_inc = poll_q + 8'd1;
	assign limit    = (tmo_q == 8'd0) ? 8'd1 : tmo_q;
	assign rem_dec  = (rem_q != 5'd0) ? (rem_q - 5'd1) : 5'd0;

	// Clamp the response length into one..MAX_RESPONSE_BYTES.
	always_comb begin
		len_sat = item_s1.response_length;
		if (len_sat == 5'd0) begin
			len_sat = 5'd1;
		end
		if (len_sat > MaxLen) begin
			len_sat = MaxLen;
		end
	end

	// Next phase and the results of the staged item.
	always_comb begin
		phase_d   = phase_q;
		poll_d    = poll_q;
		rem_d     = rem_q;
		nres_d    = 3'd0;
		take_resp = 1'b0;
		for (int k = 0; k < FRAME_BYTES; k++) begin
			res_d[k].result_kind = KIND_TX;
			res_d[k].data_byte   = frame[k];
			res_d[k].last        = (k == FRAME_BYTES - 1);
		end
		case (item_s1.opcode)
			OP_START: begin
				// start only from idle; otherwise drop the item
				if (phase_q == PH_IDLE) begin
					nres_d  = 3'(FRAME_BYTES);
					rem_d   = len_sat;
					poll_d  = 8'd0;
					phase_d = PH_WAIT;
				end
			end
			OP_RECEIVE: begin
				case (phase_q)
					PH_WAIT: begin
						if (item_s1.received_byte[BUSY_BIT]) begin
							// still busy: count the poll, give up at the limit
							if (poll_inc >= limit) begin
								res_d[0].result_kind = KIND_TIMEOUT;
								res_d[0].data_byte   = item_s1.received_byte;
								res_d[0].last        = 1'b1;
								nres_d  = 3'd1;
								phase_d = PH_IDLE;
								poll_d  = 8'd0;
								rem_d   = 5'd0;
							end else begin
								poll_d = poll_inc;
							end
						end else begin
							take_resp = 1'b1;
						end
					end
					PH_RESP: begin
						take_resp = 1'b1;
					end
					default: begin
						take_resp = 1'b0;
					end
				endcase
				if (take_resp) begin
					rem_d                = rem_dec;
					res_d[0].result_kind = KIND_RESP;
					res_d[0].data_byte   = item_s1.received_byte;
					res_d[0].last        = (rem_dec == 5'd0);
					nres_d               = 3'd1;
					if (rem_dec == 5'd0) begin
						phase_d = PH_IDLE;
						poll_d  = 8'd0;
					end else begin
						phase_d = PH_RESP;
					end
				end
			end
			default: begin
				nres_d = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			poll_q  <= 8'd0;
			rem_q   <= 5'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			poll_q  <= poll_d;
			rem_q   <= rem_d;
		end
	end

	// Queue count: reload on advance, else drop one entry per taken result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (adv) begin
			cnt_q <= nres_d;
		end else if (result_valid && result_ready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Queue entries: head at index 0, shift down as results leave.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end else if (result_valid && result_ready) begin
			for (int k = 0; k < FRAME_BYTES - 1; k++) begin
				res_s2[k] <= res_s2[k + 1];
			end
		end
	end

	// A frame byte that is not the last is always followed by another one.
	a_frame_whole: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && (result.result_kind == KIND_TX) && !result.last
		|=> result_valid && (result.result_kind == KIND_TX))
		else $error("command frame broken up");

	// Idle carries no leftover poll count or response length.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (rem_q == 5'd0) && (poll_q == 8'd0))
		else $error("stale counters in idle");

	// The queue never holds more than one frame.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(FRAME_BYTES))
		else $error("result queue overfilled");

	// A staged item that cannot advance keeps the input side stalled.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("staged item lost");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for sd_spi_command_engine: command frames with CRC7, polling,
// response collection and timeouts. A scoreboard class predicts the results.
// Depends on sdsce_pkg and the engine RTL only.
`timescale 1ns / 1ps

import sdsce_pkg::*;

// Tracks the engine's phase, poll count and remaining response bytes, and
// queues the bytes the engine must emit for every accepted item.
class sd_command_scoreboard;
	int        max_len;
	int        timeout_reg;
	phase_t    phase;
	int        polls;
	int        bytes_left;
	out_item_t expected_bytes[$];
	int        errors;
	int        frames;
	int        responses;
	int        timeouts;

	function new(int max_len_i);
		max_len     = max_len_i;
		timeout_reg = TIMEOUT_RESET;
		phase       = PH_IDLE;
		polls       = 0;
		bytes_left  = 0;
		errors      = 0;
		frames      = 0;
		responses   = 0;
		timeouts    = 0;
	endfunction

	function void set_timeout(logic [7:0] value);
		timeout_reg = value;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	// Bitwise CRC7 (x^7 + x^3 + 1) over the five header bytes, MSB first,
	// returned shifted left with the end bit set.
	function logic [7:0] crc7_tail(logic [39:0] head);
		logic [6:0] c;
		logic       fb;
		int         i;
		c = 7'h00;
		for (i = 39; i >= 0; i--) begin
			fb = c[6] ^ head[i];
			c  = {c[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
		end
		return {c, 1'b1};
	endfunction

	function void push_result(logic [1:0] kind, logic [7:0] data, logic fin);
		out_item_t r;
		r.result_kind = kind;
		r.data_byte   = data;
		r.last        = fin;
		expected_bytes.push_back(r);
	endfunction

	// Advance the predicted engine by one accepted item; return 0 when the
	// engine ignores the item.
	function bit advance_engine(in_item_t it);
		logic [39:0] head;
		int          len;
		int          limit;
		int          k;
		if (it.opcode == OP_START) begin
			if (phase != PH_IDLE)
				return 1'b0;
			head = {START_BITS | {2'b00, it.command_index}, it.command_argument};
			for (k = 4; k >= 0; k--)
				push_result(KIND_TX, head[k*8 +: 8], 1'b0);
			push_result(KIND_TX, crc7_tail(head), 1'b1);
			len = it.response_length;
			if (len == 0)
				len = 1;
			if (len > max_len)
				len = max_len;
			bytes_left = len;
			polls      = 0;
			phase      = PH_WAIT;
			frames++;
			return 1'b1;
		end
		if (phase == PH_IDLE)
			return 1'b0;
		if (phase == PH_WAIT) begin
			if (it.received_byte[BUSY_BIT]) begin
				limit = (timeout_reg == 0) ? 1 : timeout_reg;
				polls = (polls + 1) % 256;
				if (polls >= limit) begin
					push_result(KIND_TIMEOUT, it.received_byte, 1'b1);
					phase      = PH_IDLE;
					polls      = 0;
					bytes_left = 0;
					timeouts++;
				end
				return 1'b1;
			end
			phase = PH_RESP;
		end
		if (bytes_left > 0)
			bytes_left--;
		push_result(KIND_RESP, it.received_byte, bytes_left == 0);
		if (bytes_left == 0) begin
			phase = PH_IDLE;
			polls = 0;
			responses++;
		end
		return 1'b1;
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (expected_bytes.size() == 0) begin
			$error("unexpected result: result_kind %0d data_byte %02h last %0d",
				got.result_kind, got.data_byte, got.last);
			errors++;
			return;
		end
		want = expected_bytes.pop_front();
		if (got.result_kind !== want.result_kind) begin
			$error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
			errors++;
		end
		if (got.data_byte !== want.data_byte) begin
			$error("data_byte: expected %02h, actual %02h", want.data_byte, got.data_byte);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int MAX_RESP      = 17;
	localparam int ITEM_TARGET   = 450;
	localparam int SETTLE_CYCLES = 8;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_ready;
	in_item_t   item         = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	out_item_t  result;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data     = 8'h00;

	sd_command_scoreboard sb;

	// Count of items the engine acted on; ignored items do not advance it.
	int acted_count;
	// Sender burst bookkeeping and receiver stall pattern state.
	int burst_left;
	int cfg_writes;
	int stall_mode;
	int stall_hold;
	int rx_cycle;
	bit ready_next;
	int cmd_count;

	sd_spi_command_engine #(
		.MAX_RESPONSE_BYTES(MAX_RESP)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Fill every field with random bits so the fields a given opcode does not
	// use still toggle; the engine must ignore them.
	function automatic in_item_t noise_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t start_item(logic [5:0] idx, logic [31:0] arg,
			logic [4:0] len);
		in_item_t it;
		it                  = noise_item();
		it.opcode           = OP_START;
		it.command_index    = idx;
		it.command_argument = arg;
		it.response_length  = len;
		return it;
	endfunction

	function automatic in_item_t rx_item(logic [7:0] b);
		in_item_t it;
		it               = noise_item();
		it.opcode        = OP_RECEIVE;
		it.received_byte = b;
		return it;
	endfunction

	// Mostly short responses, with zero, the maximum and oversize lengths mixed in.
	function automatic logic [4:0] pick_length();
		case ($urandom_range(0, 9))
			0: return 5'd0;
			1: return 5'(MAX_RESP);
			2: return 5'($urandom_range(MAX_RESP + 1, 31));
			default: return 5'($urandom_range(1, 6));
		endcase
	endfunction

	// Extremes (zero acts as one, 255) plus reset value, small and random settings.
	function automatic logic [7:0] pick_timeout();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd255;
			4: return TIMEOUT_RESET;
			5: return 8'($urandom_range(3, 8));
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// Present one item and hold it until accepted. Called right after a rising
	// edge; valid stays high on return so a back-to-back item needs no toggle.
	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 10);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		burst_left--;
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (!item_ready);
		if (sb.advance_engine(it))
			acted_count++;
	endtask

	// Drop valid, wait for every expected byte, then let any result-free item
	// still in the input stage settle.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called after drain(), and never twice without an item in between.
	task automatic write_timeout(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_timeout(value);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// One command exchange: frame, some polls (sometimes up to the timeout),
	// then the response. A few are cut short or get a stray start item.
	task automatic run_command();
		int limit;
		int plan_polls;
		int n;
		send_item(start_item(6'($urandom), $urandom, pick_length()));
		if ($urandom_range(0, 6) == 0)
			send_item(start_item(6'($urandom), $urandom, 5'($urandom)));
		limit = (sb.timeout_reg == 0) ? 1 : sb.timeout_reg;
		if ((limit <= 16) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 19) == 0))
			plan_polls = limit;
		else
			plan_polls = $urandom_range(0, (limit - 1 < 4) ? limit - 1 : 4);
		for (n = 0; n < plan_polls && sb.phase == PH_WAIT; n++)
			send_item(rx_item(8'h80 | 8'($urandom_range(0, 127))));
		if (sb.phase == PH_WAIT)
			send_item(rx_item({1'b0, 7'($urandom)}));
		while (sb.phase == PH_RESP) begin
			if ($urandom_range(0, 39) == 0)
				break;
			send_item(rx_item(8'($urandom)));
		end
	endtask

	// Receiver: check each accepted result, then pick ready from a pattern
	// that is re-picked at random as the run goes on (always ready, coin flip,
	// one in three, long stall bursts).
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		rx_cycle = rx_cycle + 1;
		if (rx_cycle % 50 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: ready_next = 1'b1;
			1: ready_next = $urandom_range(0, 1);
			2: ready_next = (rx_cycle % 3) == 0;
			default: begin
				if (stall_hold > 0) begin
					stall_hold--;
					ready_next = 1'b0;
				end else begin
					ready_next = 1'b1;
					if ($urandom_range(0, 3) == 0)
						stall_hold = $urandom_range(1, 16);
				end
			end
		endcase
		result_ready <= ready_next;
	end

	initial begin
		sb = new(MAX_RESP);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: receive in idle is dropped; CMD0 with zero length gets a
		// one-byte response after two polls; a start during the wait is dropped.
		send_item(rx_item(8'h00));
		send_item(start_item(6'd0, 32'h0000_0000, 5'd0));
		send_item(start_item(6'd63, 32'hFFFF_FFFF, 5'd31));
		send_item(rx_item(8'hFF));
		send_item(rx_item(8'h80));
		send_item(rx_item(8'h00));
		// All-ones frame; response bytes after the first pass with bit 7 set.
		send_item(start_item(6'd63, 32'hFFFF_FFFF, 5'd3));
		send_item(rx_item(8'h7F));
		send_item(rx_item(8'hFF));
		send_item(rx_item(8'h80));
		// Zero timeout acts as one: the first poll times out.
		drain();
		write_timeout(8'd0);
		send_item(start_item(6'd1, 32'hA5A5_5A5A, 5'd1));
		send_item(rx_item(8'hFF));
		send_item(rx_item(8'h55));
		// Longest timeout; R7-style response with a start landing mid-response.
		drain();
		write_timeout(8'd255);
		send_item(start_item(6'd8, 32'h0000_01AA, 5'd5));
		send_item(rx_item(8'h80));
		send_item(rx_item(8'hC3));
		send_item(rx_item(8'h01));
		send_item(start_item(6'd55, 32'h1234_5678, 5'd2));
		send_item(rx_item(8'h00));
		send_item(rx_item(8'h00));
		send_item(rx_item(8'h01));
		send_item(rx_item(8'hAA));

		// Random: command exchanges with occasional pure noise; rewrite the
		// timeout every eight exchanges once the engine has gone quiet.
		acted_count = 0;
		while (acted_count < ITEM_TARGET) begin
			if (cmd_count % 8 == 0) begin
				drain();
				write_timeout(pick_timeout());
			end
			if ($urandom_range(0, 9) == 0)
				send_item(noise_item());
			else
				run_command();
			cmd_count++;
		end

		drain();
		$display("covered %0d command frames, %0d full responses, %0d timeouts",
			sb.frames, sb.responses, sb.timeouts);
		$display("across %0d timeout settings, with %0d mismatches", cfg_writes, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("watchdog expired, %0d results outstanding", sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
